[hdl/ccsg_pkg.sv]
// Shared types and constants for the coulomb counter state-of-charge gauge.
`default_nettype none

package ccsg_pkg;

    // Default width of the kept capacity and of the charge datapath
    localparam int CHARGE_BITS_DEF = 31;

    // Fixed port widths
    localparam int CAP_PORT_W = 31;
    localparam int DELTA_W    = 32;
    localparam int PCT_W      = 8;
    localparam int CHG_OUT_W  = 33;
    localparam int STATUS_W   = 3;

    // Capacity after reset, in mAs
    localparam logic [63:0] CAP_RESET = 64'd3600000;

    // Percent scale and status thresholds
    localparam logic [PCT_W-1:0] PCT_FULL     = 8'd100;
    localparam logic [PCT_W-1:0] PCT_NORMAL_T = 8'd20;
    localparam logic [PCT_W-1:0] PCT_LOW_T    = 8'd10;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DELTA = 1'b1;

    // Pack status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL   = 3'd0,
        ST_LOW      = 3'd1,
        ST_CRITICAL = 3'd2,
        ST_FULL     = 3'd3,
        ST_FAULT    = 3'd4
    } pack_status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CLAMP,
        S_MUL,
        S_DIV,
        S_WB,
        S_FINISH
    } gauge_state_t;

endpackage : ccsg_pkg

`default_nettype wire

[hdl/coulomb_counter_soc_gauge.sv]
// Top level of the coulomb counter state-of-charge gauge.
`default_nettype none

// Battery fuel gauge. A load word (operation 0) sets the charge to
// capacity * initial_percent / 100 and keeps that percentage; a delta word
// (operation 1) adds charge_delta, clamps the sum to 0..capacity and sets
// soc_now to charge * 100 / capacity. Every word returns one result word
// with the pack status. One word is in work at a time: a load runs the
// multiply, divide and write-back steps, and a delta first adds and
// clamps and then runs the same steps; a delta with zero capacity skips
// the multiply, divide and write-back. The input is ready again in the
// same cycle that the result appears in the output register. The divides
// run in the shared restoring divider, which retires one quotient bit per
// cycle over the CHARGE_BITS + 8 bit scaled dividend. The input side is
// stalled while a word is in work; a finished result waits in the output
// register, so the next word may be accepted before it is taken.
// The capacity register may only be written while the gauge is idle.
module coulomb_counter_soc_gauge #(
    parameter int CHARGE_BITS = ccsg_pkg::CHARGE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // capacity register
    input  wire logic                               capacity_wr,
    input  wire logic [ccsg_pkg::CAP_PORT_W-1:0]    capacity,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               operation,
    input  wire logic [ccsg_pkg::DELTA_W-1:0]       charge_delta,
    input  wire logic [ccsg_pkg::PCT_W-1:0]         initial_percent,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [ccsg_pkg::CHG_OUT_W-1:0]          charge_now,
    output logic [ccsg_pkg::PCT_W-1:0]              soc_now,
    output logic [ccsg_pkg::STATUS_W-1:0]           pack_status
);

    import ccsg_pkg::*;

    localparam int CB    = CHARGE_BITS;
    localparam int CW    = CHARGE_BITS + 2;               // stored charge
    localparam int W     = CHARGE_BITS + PCT_W;            // scaled dividend
    localparam int SW    = ((CW > DELTA_W) ? CW : DELTA_W) + 1;
    localparam int CNT_W = $clog2(W);
    localparam logic [63:0] CAP_RESET_V = CAP_RESET;

    // Control state
    gauge_state_t              state_reg, state_next;
    logic [CB-1:0]             cap_reg;
    logic [CW-1:0]             charge_reg, charge_next;
    logic [PCT_W-1:0]          pct_reg, pct_next;
    pack_status_t              status_reg, status_next;
    logic                      out_valid_reg, out_valid_next;

    // Datapath registers
    logic                      op_reg, op_next;
    logic [DELTA_W-1:0]        delta_reg, delta_next;
    logic [PCT_W-1:0]          pct_in_reg, pct_in_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic [W-1:0]              dvd_reg, dvd_next;
    logic [CB-1:0]             rem_reg, rem_next;
    logic [CB-1:0]             dsr_reg, dsr_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CHG_OUT_W-1:0]      chg_out_reg, chg_out_next;
    logic [PCT_W-1:0]          soc_out_reg, soc_out_next;
    pack_status_t              st_out_reg, st_out_next;

    // Shared arithmetic
    logic [63:0]               cap_wide;
    logic [63:0]               chg_wide;
    logic [CB-1:0]             mul_a;
    logic [PCT_W-1:0]          mul_b;
    logic [W-1:0]              prod;
    logic [CB:0]               trial;
    logic                      q_bit;
    logic signed [SW-1:0]      sum_wide;
    logic [CB-1:0]             clamped;
    pack_status_t              class_st;
    logic                      in_acc;
    logic                      out_free;
    logic                      div_last;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign div_last = (cnt_reg == CNT_W'(W - 1));
    assign cap_wide = 64'(capacity);
    assign chg_wide = 64'(charge_reg);

    // Multiplier operands: cap * percent on load, charge * 100 on delta
    assign mul_a = (op_reg == OP_DELTA) ? charge_reg[CB-1:0] : cap_reg;
    assign mul_b = (op_reg == OP_DELTA) ? PCT_FULL : pct_in_reg;
    assign prod  = W'(mul_a) * W'(mul_b);

    // One restoring divide step
    assign trial = {rem_reg, dvd_reg[W-1]};
    assign q_bit = (trial >= {1'b0, dsr_reg});

    // Wide signed sum of stored charge and delta
    assign sum_wide = $signed({{(SW-CW){1'b0}}, charge_reg})
                    + $signed({{(SW-DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg});

    // Clamp the registered sum to zero through capacity
    always_comb
    begin
        if (sum_reg[SW-1])
        begin
            clamped = '0;
        end
        else if (sum_reg > $signed({{(SW-CB){1'b0}}, cap_reg}))
        begin
            clamped = cap_reg;
        end
        else
        begin
            clamped = sum_reg[CB-1:0];
        end
    end

    // Classify the pack from the stored percent and charge
    always_comb
    begin
        if ((pct_reg > PCT_FULL) || (charge_reg > {2'b00, cap_reg}))
        begin
            class_st = ST_FAULT;
        end
        else if (pct_reg == PCT_FULL)
        begin
            class_st = ST_FULL;
        end
        else if (pct_reg > PCT_NORMAL_T)
        begin
            class_st = ST_NORMAL;
        end
        else if (pct_reg > PCT_LOW_T)
        begin
            class_st = ST_LOW;
        end
        else
        begin
            class_st = ST_CRITICAL;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (operation == OP_DELTA) ? S_ADD : S_MUL;
                end
            end
            S_ADD:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = (cap_reg == '0) ? S_FINISH : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and store updates
    always_comb
    begin
        charge_next    = charge_reg;
        pct_next       = pct_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        delta_next     = delta_reg;
        pct_in_next    = pct_in_reg;
        sum_next       = sum_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        cnt_next       = cnt_reg;
        chg_out_next   = chg_out_reg;
        soc_out_next   = soc_out_reg;
        st_out_next    = st_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                // capture the word
                if (in_acc)
                begin
                    op_next     = operation;
                    delta_next  = charge_delta;
                    pct_in_next = initial_percent;
                end
            end
            S_ADD:
            begin
                sum_next = sum_wide;
            end
            S_CLAMP:
            begin
                // zero capacity gives zero charge and zero percent
                charge_next = CW'(clamped);
                if (cap_reg == '0)
                begin
                    pct_next = '0;
                end
            end
            S_MUL:
            begin
                // load the divider with the scaled dividend
                dvd_next = prod;
                rem_next = '0;
                dsr_next = (op_reg == OP_DELTA) ? cap_reg : CB'(PCT_FULL);
                cnt_next = '0;
            end
            S_DIV:
            begin
                // retire one quotient bit
                dvd_next = {dvd_reg[W-2:0], q_bit};
                rem_next = q_bit ? CB'(trial - {1'b0, dsr_reg}) : trial[CB-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
            S_WB:
            begin
                if (op_reg == OP_DELTA)
                begin
                    pct_next = dvd_reg[PCT_W-1:0];
                end
                else
                begin
                    charge_next = dvd_reg[CW-1:0];
                    pct_next    = pct_in_reg;
                end
            end
            S_FINISH:
            begin
                // classify and present the result word
                if (out_free)
                begin
                    status_next    = class_st;
                    chg_out_next   = chg_wide[CHG_OUT_W-1:0];
                    soc_out_next   = pct_reg;
                    st_out_next    = class_st;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET_V[CB-1:0];
            charge_reg    <= '0;
            pct_reg       <= '0;
            status_reg    <= ST_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (capacity_wr)
            begin
                cap_reg <= cap_wide[CB-1:0];
            end
            charge_reg    <= charge_next;
            pct_reg       <= pct_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        delta_reg   <= delta_next;
        pct_in_reg  <= pct_in_next;
        sum_reg     <= sum_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        cnt_reg     <= cnt_next;
        chg_out_reg <= chg_out_next;
        soc_out_reg <= soc_out_next;
        st_out_reg  <= st_out_next;
    end

    // Ports
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign charge_now  = chg_out_reg;
    assign soc_now     = soc_out_reg;
    assign pack_status = st_out_reg;

endmodule : coulomb_counter_soc_gauge

`default_nettype wire

[hdl/ccsg_checker.sv]
// Port-level checker for the coulomb counter state-of-charge gauge, with its bind.
`default_nettype none

module ccsg_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic [ccsg_pkg::CHG_OUT_W-1:0]     charge_now,
    input  wire logic [ccsg_pkg::PCT_W-1:0]         soc_now,
    input  wire logic [ccsg_pkg::STATUS_W-1:0]      pack_status
);

    import ccsg_pkg::*;

    // An accepted word keeps the gauge busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("gauge accepted a word without going busy");

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(charge_now)
            && $stable(soc_now) && $stable(pack_status)))
        else $error("stalled result word changed");

    // Percent above full always reports a fault
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (soc_now > PCT_FULL)) |-> (pack_status == ST_FAULT))
        else $error("over-full percent without fault status");

    // Full status only at exactly full percent
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (pack_status == ST_FULL)) |-> (soc_now == PCT_FULL))
        else $error("full status with wrong percent");

    // Low percent without fault is critical
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (soc_now <= PCT_LOW_T) && (pack_status != ST_FAULT))
            |-> (pack_status == ST_CRITICAL))
        else $error("low percent not reported critical");

endmodule : ccsg_checker

bind coulomb_counter_soc_gauge ccsg_checker u_ccsg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .charge_now      (charge_now),
    .soc_now         (soc_now),
    .pack_status     (pack_status)
);

`default_nettype wire
